// ===== src/ffba_pkg.sv =====
// Shared types, constants and codes for the first-fit block allocator.
package ffba_pkg;

    localparam int NUM_BLOCKS_DEF  = 256;
    localparam int BLOCK_BYTES_DEF = 4096;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] STATUS_ALLOC_OK   = 2'd0;
    localparam logic [1:0] STATUS_ALLOC_FAIL = 2'd1;
    localparam logic [1:0] STATUS_FREED      = 2'd2;
    localparam logic [1:0] STATUS_IGNORED    = 2'd3;

    typedef logic [8:0] used_cnt_t;

    typedef struct packed {
        logic        operation;
        logic [20:0] size_bytes;
        logic [31:0] address;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_address;
        used_cnt_t   blocks_in_use;
    } rsp_t;

endpackage

// ===== src/first_fit_block_allocator.sv =====
// Top level of the first-fit bitmap block allocator.
//
//  channel   signals                     beat taken when
//  request   start, busy, req            start && !busy
//  result    done, rsp                   done (one cycle, no backpressure)
//  config    cfg_valid, cfg_ready, data  cfg_valid && cfg_ready
//
// After reset the used map is swept clear, with busy high.
// Every accepted request passes through the decide state first.
// Free: the index comes from repeated subtraction of BLOCK_BYTES, then the map bit is read and cleared if set.
// Allocate: scan the map for a free run that covers the size, then mark that run; one map bit per cycle.
// Zero or oversize allocate and address zero or out-of-range free end in the decide state.
// The result register frees the block for a new request in the cycle done shows.
module first_fit_block_allocator #(
    parameter int NUM_BLOCKS  = ffba_pkg::NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = ffba_pkg::BLOCK_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ffba_pkg::req_t req,
    output logic           done,
    output ffba_pkg::rsp_t rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [31:0]    cfg_data
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam logic [31:0] BLOCK_STEP = 32'(BLOCK_BYTES);
    localparam logic [31:0] HEAP_SPAN  = 32'(NUM_BLOCKS * BLOCK_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_FREE_IDX = 3'd2;
    localparam logic [2:0] ST_DECIDE   = 3'd3;
    localparam logic [2:0] ST_SCAN     = 3'd4;
    localparam logic [2:0] ST_MARK     = 3'd5;
    localparam logic [2:0] ST_FREE_CHK = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] chk_reg, chk_next;
    logic [IDX_W-1:0] first_idx_reg, first_idx_next;
    logic [CNT_W-1:0] run_reg, run_next;
    logic [31:0]      run_bytes_reg, run_bytes_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      first_addr_reg, first_addr_next;
    logic [31:0]      cur_addr_reg, cur_addr_next;
    logic [31:0]      heap_base_reg;
    logic             op_reg, op_next;
    logic             zero_reg, zero_next;
    logic [20:0]      size_reg, size_next;
    logic [31:0]      rem_reg, rem_next;
    logic             done_reg, done_next;
    ffba_pkg::rsp_t   rsp_reg, rsp_next;

    logic [CNT_W-1:0] run_inc;
    logic [31:0]      run_bytes_inc;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic             ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic             ram_rdata;

    ffba_ram #(
        .WIDTH (1),
        .DEPTH (NUM_BLOCKS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    assign run_inc       = run_reg + CNT_W'(1);
    assign run_bytes_inc = run_bytes_reg + BLOCK_STEP;

    always_comb
    begin
        state_next      = state_reg;
        chk_next        = chk_reg;
        first_idx_next  = first_idx_reg;
        run_next        = run_reg;
        run_bytes_next  = run_bytes_reg;
        count_next      = count_reg;
        first_addr_next = first_addr_reg;
        cur_addr_next   = cur_addr_reg;
        op_next         = op_reg;
        zero_next       = zero_reg;
        size_next       = size_reg;
        rem_next        = rem_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        ram_we          = 1'b0;
        ram_waddr       = chk_reg;
        ram_wdata       = 1'b0;
        ram_raddr       = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (chk_reg == LAST_IDX)
                begin
                    chk_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    chk_next = chk_reg + IDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = req.operation;
                    zero_next  = (req.address == 32'd0);
                    size_next  = req.size_bytes;
                    rem_next   = req.address - heap_base_reg;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (op_reg == ffba_pkg::OP_ALLOC)
                begin
                    if (size_reg == 21'd0 || 32'(size_reg) > HEAP_SPAN)
                    begin
                        done_next               = 1'b1;
                        rsp_next.status         = ffba_pkg::STATUS_ALLOC_FAIL;
                        rsp_next.result_address = 32'd0;
                        rsp_next.blocks_in_use  = ffba_pkg::used_cnt_t'(count_reg);
                        state_next              = ST_IDLE;
                    end
                    else
                    begin
                        ram_raddr      = '0;
                        chk_next       = '0;
                        run_next       = '0;
                        run_bytes_next = '0;
                        cur_addr_next  = heap_base_reg;
                        state_next     = ST_SCAN;
                    end
                end
                else
                begin
                    if (zero_reg || rem_reg >= HEAP_SPAN)
                    begin
                        done_next               = 1'b1;
                        rsp_next.status         = ffba_pkg::STATUS_IGNORED;
                        rsp_next.result_address = 32'd0;
                        rsp_next.blocks_in_use  = ffba_pkg::used_cnt_t'(count_reg);
                        state_next              = ST_IDLE;
                    end
                    else
                    begin
                        chk_next   = '0;
                        state_next = ST_FREE_IDX;
                    end
                end
            end
            ST_FREE_IDX:
            begin
                if (rem_reg >= BLOCK_STEP)
                begin
                    rem_next = rem_reg - BLOCK_STEP;
                    chk_next = chk_reg + IDX_W'(1);
                end
                else
                begin
                    ram_raddr  = chk_reg;
                    state_next = ST_FREE_CHK;
                end
            end
            ST_SCAN:
            begin
                ram_raddr = chk_reg + IDX_W'(1);
                if (!ram_rdata)
                begin
                    if (run_reg == '0)
                    begin
                        first_idx_next  = chk_reg;
                        first_addr_next = cur_addr_reg;
                    end
                    run_next       = run_inc;
                    run_bytes_next = run_bytes_inc;
                end
                else
                begin
                    run_next       = '0;
                    run_bytes_next = '0;
                end
                if (!ram_rdata && run_bytes_inc >= 32'(size_reg))
                begin
                    state_next = ST_MARK;
                end
                else if (chk_reg == LAST_IDX)
                begin
                    done_next               = 1'b1;
                    rsp_next.status         = ffba_pkg::STATUS_ALLOC_FAIL;
                    rsp_next.result_address = 32'd0;
                    rsp_next.blocks_in_use  = ffba_pkg::used_cnt_t'(count_reg);
                    state_next              = ST_IDLE;
                end
                else
                begin
                    chk_next      = chk_reg + IDX_W'(1);
                    cur_addr_next = cur_addr_reg + BLOCK_STEP;
                end
            end
            ST_MARK:
            begin
                ram_we    = 1'b1;
                ram_waddr = first_idx_reg;
                ram_wdata = 1'b1;
                if (first_idx_reg == chk_reg)
                begin
                    count_next              = count_reg + run_reg;
                    done_next               = 1'b1;
                    rsp_next.status         = ffba_pkg::STATUS_ALLOC_OK;
                    rsp_next.result_address = first_addr_reg;
                    rsp_next.blocks_in_use  = ffba_pkg::used_cnt_t'(count_next);
                    state_next              = ST_IDLE;
                end
                else
                begin
                    first_idx_next = first_idx_reg + IDX_W'(1);
                end
            end
            ST_FREE_CHK:
            begin
                done_next               = 1'b1;
                rsp_next.result_address = 32'd0;
                state_next              = ST_IDLE;
                if (ram_rdata)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = chk_reg;
                    ram_wdata       = 1'b0;
                    count_next      = count_reg - CNT_W'(1);
                    rsp_next.status = ffba_pkg::STATUS_FREED;
                end
                else
                begin
                    rsp_next.status = ffba_pkg::STATUS_IGNORED;
                end
                rsp_next.blocks_in_use = ffba_pkg::used_cnt_t'(count_next);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            chk_reg       <= '0;
            count_reg     <= '0;
            heap_base_reg <= 32'd0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chk_reg   <= chk_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                heap_base_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        first_idx_reg  <= first_idx_next;
        run_reg        <= run_next;
        run_bytes_reg  <= run_bytes_next;
        first_addr_reg <= first_addr_next;
        cur_addr_reg   <= cur_addr_next;
        op_reg         <= op_next;
        zero_reg       <= zero_next;
        size_reg       <= size_next;
        rem_reg        <= rem_next;
        rsp_reg        <= rsp_next;
    end

endmodule

// ===== src/ffba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ffba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/ffba_checker.sv =====
// Port-level assertions for the allocator and the bind that attaches them.
module ffba_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input ffba_pkg::req_t req,
    input logic           done,
    input ffba_pkg::rsp_t rsp,
    input logic           cfg_valid,
    input logic           cfg_ready,
    input logic [31:0]    cfg_data
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without preceding work");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ffba_pkg::STATUS_ALLOC_OK) |-> (rsp.result_address == 32'd0))
        else $error("nonzero address on a failed allocate or a free");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);
